FILE: hw/rtl/sce_pkg.sv
// Shared types and constants for the seam cumulative energy unit.
`timescale 1ns / 1ps
package sce_pkg;

  localparam int GRAD_W     = 11;
  localparam int ENERGY_W   = 22;
  localparam int COLUMN_W   = 10;
  localparam int IMG_W_BITS = 11;
  localparam int IMG_H_BITS = 12;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_ADDR_W = 1;

  localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};

  // Predecessor direction codes
  localparam logic [1:0] DIR_UL   = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_UR   = 2'd2;
  localparam logic [1:0] DIR_NONE = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  // Position of a pixel within its frame
  typedef struct packed {
    logic first_row;
    logic first_col;
    logic last_col;
    logic last_row;
  } pix_pos_t;

endpackage

FILE: hw/rtl/seam_cumulative_energy_unit.sv
// Top level: position counters, line-store read stage, cost unit and output register.
// An accepted beat goes through the compute-stage registers, then the output register.
// Throughput: one pixel per cycle unless the output stalls; the line store serves both
// neighbor reads and the prior pixel's write-back in the same cycle, with write bypass.
// Reset: clears the counters, pipeline valids, up-left hold and bottom-row tracker,
// and sets the image size to 1024 x 2048; the line store is not cleared.
`timescale 1ns / 1ps
module seam_cumulative_energy_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration write port
  input  logic                            cfg_we,
  input  logic [sce_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [sce_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // Pixel input
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [15:0]                     s_tdata,  // gradient[10:0], zeros above
  // Result output
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [71:0]                     m_tdata,  // energy[21:0], direction[23:22],
                                                    // column[33:24], seam_end_column[43:34],
                                                    // seam_end_energy[65:44], zeros above
  output logic                            m_tlast   // frame_end
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WB    = ($clog2(MAX_WIDTH + 1) > sce_pkg::IMG_W_BITS) ?
                         $clog2(MAX_WIDTH + 1) : sce_pkg::IMG_W_BITS;
  localparam int HB    = ($clog2(MAX_HEIGHT + 1) > sce_pkg::IMG_H_BITS) ?
                         $clog2(MAX_HEIGHT + 1) : sce_pkg::IMG_H_BITS;

  logic [sce_pkg::IMG_W_BITS-1:0] image_width;
  logic [sce_pkg::IMG_H_BITS-1:0] image_height;
  logic [WB-1:0]                  width_eff;
  logic [HB-1:0]                  height_eff;

  logic [COL_W-1:0]               col_count;
  logic [ROW_W-1:0]               row_count;
  logic                           last_col_in;
  logic                           last_row_in;
  logic [COL_W-1:0]               ur_addr;

  logic                           accept;
  logic                           step;
  logic                           busy;
  sce_pkg::pix_pos_t              pos;
  logic [sce_pkg::GRAD_W-1:0]     grad;
  logic [COL_W-1:0]               col;

  logic [sce_pkg::ENERGY_W-1:0]   up;
  logic [sce_pkg::ENERGY_W-1:0]   up_right;
  logic [sce_pkg::ENERGY_W-1:0]   energy;
  logic [1:0]                     direction;
  logic [COL_W-1:0]               best_col_next;
  logic [sce_pkg::ENERGY_W-1:0]   best_energy_next;
  logic                           frame_end;

  logic [sce_pkg::ENERGY_W-1:0]   out_energy;
  logic [1:0]                     out_direction;
  logic [sce_pkg::COLUMN_W-1:0]   out_column;
  logic [sce_pkg::COLUMN_W-1:0]   out_seam_col;
  logic [sce_pkg::ENERGY_W-1:0]   out_seam_energy;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= sce_pkg::IMG_W_BITS'(1024);
      image_height <= sce_pkg::IMG_H_BITS'(2048);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        sce_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_wdata[sce_pkg::IMG_W_BITS-1:0];
        sce_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_wdata[sce_pkg::IMG_H_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the image size to the supported range
  always_comb begin
    width_eff = WB'(image_width);
    if (width_eff < WB'(2)) width_eff = WB'(2);
    if (width_eff > WB'(MAX_WIDTH)) width_eff = WB'(MAX_WIDTH);
    height_eff = HB'(image_height);
    if (height_eff < HB'(1)) height_eff = HB'(1);
    if (height_eff > HB'(MAX_HEIGHT)) height_eff = HB'(MAX_HEIGHT);
  end

  assign last_col_in = (WB'(col_count) + WB'(1)) >= width_eff;
  assign last_row_in = (HB'(row_count) + HB'(1)) >= height_eff;
  assign ur_addr     = last_col_in ? col_count : col_count + COL_W'(1);

  // Handshake: the compute stage moves when the output register is free or draining
  assign step     = busy && (!m_tvalid || m_tready);
  assign s_tready = !busy || step;
  assign accept   = s_tvalid && s_tready;

  // Advance the raster position on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (last_col_in) begin
        col_count <= '0;
        row_count <= last_row_in ? '0 : row_count + ROW_W'(1);
      end else begin
        col_count <= col_count + COL_W'(1);
      end
    end
  end

  // Compute stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
    end else if (step) begin
      busy <= 1'b0;
    end
  end

  // Capture the pixel alongside its line-store reads
  always_ff @(posedge clk) begin
    if (accept) begin
      grad          <= s_tdata[sce_pkg::GRAD_W-1:0];
      col           <= col_count;
      pos.first_row <= (row_count == '0);
      pos.first_col <= (col_count == '0);
      pos.last_col  <= last_col_in;
      pos.last_row  <= last_row_in;
    end
  end

  sce_line_store #(
    .DEPTH  (MAX_WIDTH),
    .ADDR_W (COL_W)
  ) u_line_store (
    .clk    (clk),
    .re     (accept),
    .raddr0 (col_count),
    .raddr1 (ur_addr),
    .rdata0 (up),
    .rdata1 (up_right),
    .we     (step),
    .waddr  (col),
    .wdata  (energy)
  );

  sce_cost_unit #(
    .COL_W (COL_W)
  ) u_cost_unit (
    .clk              (clk),
    .rst              (rst),
    .step             (step),
    .pos              (pos),
    .grad             (grad),
    .col              (col),
    .up               (up),
    .up_right         (up_right),
    .energy           (energy),
    .direction        (direction),
    .best_col_next    (best_col_next),
    .best_energy_next (best_energy_next)
  );

  assign frame_end = pos.last_col && pos.last_row;

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (step) begin
      out_energy      <= energy;
      out_direction   <= direction;
      out_column      <= sce_pkg::COLUMN_W'(col);
      m_tlast         <= frame_end;
      out_seam_col    <= frame_end ? sce_pkg::COLUMN_W'(best_col_next) : '0;
      out_seam_energy <= frame_end ? best_energy_next : '0;
    end
  end

  assign m_tdata = {6'd0, out_seam_energy, out_seam_col, out_column, out_direction, out_energy};

endmodule

FILE: hw/rtl/sce_line_store.sv
// Previous-row energy store: one write port, two registered read ports with write bypass.
`timescale 1ns / 1ps
module sce_line_store #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic                          clk,
  input  logic                          re,
  input  logic [ADDR_W-1:0]             raddr0,
  input  logic [ADDR_W-1:0]             raddr1,
  output logic [sce_pkg::ENERGY_W-1:0]  rdata0,
  output logic [sce_pkg::ENERGY_W-1:0]  rdata1,
  input  logic                          we,
  input  logic [ADDR_W-1:0]             waddr,
  input  logic [sce_pkg::ENERGY_W-1:0]  wdata
);

  logic [sce_pkg::ENERGY_W-1:0] mem [DEPTH];

  // Write the finished energy of the pixel leaving the compute stage
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read both neighbors; forward a write to the same entry in this cycle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata0 <= (we && waddr == raddr0) ? wdata : mem[raddr0];
      rdata1 <= (we && waddr == raddr1) ? wdata : mem[raddr1];
    end
  end

endmodule

FILE: hw/rtl/sce_cost_unit.sv
// Predecessor selection, saturating add, up-left hold and bottom-row minimum tracker.
`timescale 1ns / 1ps
module sce_cost_unit #(
  parameter int COL_W = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  sce_pkg::pix_pos_t             pos,
  input  logic [sce_pkg::GRAD_W-1:0]    grad,
  input  logic [COL_W-1:0]              col,
  input  logic [sce_pkg::ENERGY_W-1:0]  up,
  input  logic [sce_pkg::ENERGY_W-1:0]  up_right,
  output logic [sce_pkg::ENERGY_W-1:0]  energy,
  output logic [1:0]                    direction,
  output logic [COL_W-1:0]              best_col_next,
  output logic [sce_pkg::ENERGY_W-1:0]  best_energy_next
);

  logic [sce_pkg::ENERGY_W-1:0] up_left;
  logic [sce_pkg::ENERGY_W-1:0] best_energy;
  logic [COL_W-1:0]             best_col;

  logic [sce_pkg::ENERGY_W-1:0] pred;
  logic [sce_pkg::ENERGY_W-1:0] pred_mid;
  logic [1:0]                   dir_mid;
  logic [sce_pkg::ENERGY_W:0]   sum;
  logic                         take_best;

  // Pick the least predecessor with the edge-specific tie rules
  always_comb begin
    pred_mid  = up;
    dir_mid   = sce_pkg::DIR_UP;
    pred      = '0;
    direction = sce_pkg::DIR_NONE;
    if (up_left < up) begin
      pred_mid = up_left;
      dir_mid  = sce_pkg::DIR_UL;
    end
    if (pos.first_row) begin
      pred      = '0;
      direction = sce_pkg::DIR_NONE;
    end else if (pos.first_col) begin
      if (up < up_right) begin
        pred      = up;
        direction = sce_pkg::DIR_UP;
      end else begin
        pred      = up_right;
        direction = sce_pkg::DIR_UR;
      end
    end else if (pos.last_col) begin
      if (up < up_left) begin
        pred      = up;
        direction = sce_pkg::DIR_UP;
      end else begin
        pred      = up_left;
        direction = sce_pkg::DIR_UL;
      end
    end else begin
      if (up_right < pred_mid) begin
        pred      = up_right;
        direction = sce_pkg::DIR_UR;
      end else begin
        pred      = pred_mid;
        direction = dir_mid;
      end
    end
  end

  // Add the gradient and clamp at the top of the range
  assign sum    = {1'b0, pred} + {{(sce_pkg::ENERGY_W + 1 - sce_pkg::GRAD_W){1'b0}}, grad};
  assign energy = sum[sce_pkg::ENERGY_W] ? sce_pkg::ENERGY_MAX : sum[sce_pkg::ENERGY_W-1:0];

  // Track the rightmost least energy of the bottom row
  assign take_best        = pos.last_row && (pos.first_col || energy <= best_energy);
  assign best_energy_next = take_best ? energy : best_energy;
  assign best_col_next    = take_best ? col : best_col;

  // Hold this pixel's up value as the next pixel's up-left
  always_ff @(posedge clk) begin
    if (rst) begin
      up_left <= '0;
    end else if (step) begin
      up_left <= up;
    end
  end

  // Update the tracker; clear it once the frame closes
  always_ff @(posedge clk) begin
    if (rst) begin
      best_energy <= sce_pkg::ENERGY_MAX;
      best_col    <= '0;
    end else if (step) begin
      if (pos.last_row && pos.last_col) begin
        best_energy <= sce_pkg::ENERGY_MAX;
        best_col    <= '0;
      end else begin
        best_energy <= best_energy_next;
        best_col    <= best_col_next;
      end
    end
  end

endmodule
